[rtl/rc4ks_pkg.sv]
// ----------------------------------------------------------------------------
// rc4ks_pkg
// Shared types and constants for the RC4 keystream cipher block.
// ----------------------------------------------------------------------------
package rc4ks_pkg;

    localparam int MAX_STATE     = 256;
    localparam int MAX_KEY_BYTES = 16;
    localparam int ADDR_W        = $clog2(MAX_STATE);
    localparam int SIZE_W        = 9;
    localparam int KLEN_W        = 5;
    localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
    localparam int SUM_W         = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int SHIFT_W       = 4;
    localparam int MOD_TOP_SHIFT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERM_SIZE = 2'd0,
        REG_KEY_LEN   = 2'd1,
        REG_KEY_LOW   = 2'd2,
        REG_KEY_HIGH  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_REKEY = 1'b0,
        KIND_DATA  = 1'b1
    } kind_t;

    // Destination of a finished modulo reduction.
    typedef enum logic [1:0] {
        DST_I = 2'd0,
        DST_J = 2'd1,
        DST_T = 2'd2
    } dst_t;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_FILL    = 15'b000000000000010,
        ST_SCH_RDK = 15'b000000000000100,
        ST_SCH_J   = 15'b000000000001000,
        ST_SCH_RDJ = 15'b000000000010000,
        ST_SCH_SW1 = 15'b000000000100000,
        ST_SCH_SW2 = 15'b000000001000000,
        ST_D_RDI   = 15'b000000010000000,
        ST_D_J     = 15'b000000100000000,
        ST_D_RDJ   = 15'b000001000000000,
        ST_D_SW1   = 15'b000010000000000,
        ST_D_SW2   = 15'b000100000000000,
        ST_D_RDT   = 15'b001000000000000,
        ST_D_OUT   = 15'b010000000000000,
        ST_MOD     = 15'b100000000000000
    } state_t;

endpackage

[rtl/rc4_keystream_cipher.sv]
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// RC4 keystream generator and byte cipher with a configurable permutation size.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel : cfg_valid/cfg_ready with cfg_index and cfg_data. Registers are
//                 the table size N (2..256), the key length (1..16), key_low
//                 and key_high (key bytes 0..7 and 8..15). Write only while idle.
//   s channel   : one request per item. s_kind = rekey runs the key schedule
//                 and gives no result; s_kind = data encrypts s_data_byte.
//   m channel   : one result per data request: m_keystream_value = S[t] and
//                 m_cipher_byte = data byte XOR S[t].
// Datapath: all work goes through one permutation RAM (one read and one
//   write port) and one adder with a modulo-N reducer, stepped by a one-hot
//   sequencer. A data request advances i, reads S[i], forms j, reads S[j],
//   writes the swap, reads S[t] and gives the result; a new request is taken
//   only back in idle. Each modulo reduction of a sum at or above 3N (only
//   after N shrinks without a rekey, or with key bytes far above N) runs the
//   iterative shift-and-subtract. A rekey writes the identity fill, then per
//   schedule entry reads S[k], forms j, reads S[j] and writes the swap.
// Reset clears i, j, the sequencer and the registers (N = 256, 16 key bytes,
//   key zero). The permutation is undefined until the first rekey.
// A stalled receiver holds the result in its register; the next request is
//   still accepted and worked, and the block waits only if a second result is ready.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rc4ks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                cfg_data,
    // input requests
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [7:0]                 s_data_byte,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_keystream_value,
    output logic [7:0]                 m_cipher_byte
);

    import rc4ks_pkg::*;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0] perm_size_reg;
    logic [KLEN_W-1:0] key_len_reg;
    logic [63:0]       key_low_reg;
    logic [63:0]       key_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_size_reg  <= SIZE_W'(MAX_STATE);
            key_len_reg    <= KLEN_W'(MAX_KEY_BYTES);
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_PERM_SIZE: perm_size_reg <= cfg_data[SIZE_W-1:0];
                REG_KEY_LEN:   key_len_reg   <= cfg_data[KLEN_W-1:0];
                REG_KEY_LOW:   key_low_reg   <= cfg_data;
                REG_KEY_HIGH:  key_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Clamp the registers to their legal ranges.
    logic [SIZE_W-1:0] n_eff;
    logic [KLEN_W-1:0] klen_eff;

    always_comb begin
        if (perm_size_reg < SIZE_W'(2)) begin
            n_eff = SIZE_W'(2);
        end else if (perm_size_reg > SIZE_W'(MAX_STATE)) begin
            n_eff = SIZE_W'(MAX_STATE);
        end else begin
            n_eff = perm_size_reg;
        end
        if (key_len_reg < KLEN_W'(1)) begin
            klen_eff = KLEN_W'(1);
        end else if (key_len_reg > KLEN_W'(MAX_KEY_BYTES)) begin
            klen_eff = KLEN_W'(MAX_KEY_BYTES);
        end else begin
            klen_eff = key_len_reg;
        end
    end

    // ---------------- sequencer and datapath registers ----------------
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;     // where to go after a reduction
    dst_t                dst_reg, dst_next;     // which index a reduction lands in
    logic [ADDR_W-1:0]   i_reg, i_next;
    logic [ADDR_W-1:0]   j_reg, j_next;         // also the schedule's running j
    logic [ADDR_W-1:0]   t_reg, t_next;
    logic [SIZE_W-1:0]   k_reg, k_next;         // schedule entry counter
    logic [KIDX_W-1:0]   kidx_reg, kidx_next;   // key byte index, wraps at key length
    logic [7:0]          si_reg, si_next;       // S[i] (or S[k] in the schedule)
    logic [7:0]          sj_reg, sj_next;
    logic [7:0]          data_reg, data_next;
    logic [SUM_W-1:0]    mod_val_reg, mod_val_next;
    logic [SHIFT_W-1:0]  sh_reg, sh_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          ks_out_reg, ks_out_next;
    logic [7:0]          cb_out_reg, cb_out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            dst_reg     <= DST_I;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            kidx_reg    <= '0;
            sh_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            dst_reg     <= dst_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            kidx_reg    <= kidx_next;
            sh_reg      <= sh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        si_reg      <= si_next;
        sj_reg      <= sj_next;
        data_reg    <= data_next;
        mod_val_reg <= mod_val_next;
        ks_out_reg  <= ks_out_next;
        cb_out_reg  <= cb_out_next;
    end

    // ---------------- permutation RAM ----------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wa;
    logic [7:0]        ram_wd;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_ra;
    logic [7:0]        ram_rd;

    rc4ks_ram #(
        .WIDTH (8),
        .DEPTH (MAX_STATE)
    ) u_perm_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // ---------------- shared adder and modulo-N reducer ----------------
    logic [SUM_W-1:0]   op_a, op_b, op_c, sum;
    logic [SUM_W-1:0]   n10, n2;
    logic [SUM_W:0]     n3;
    logic               fast_ok;
    logic [SUM_W-1:0]   fast_val;
    logic [17:0]        mod_cmp, mod_ext;
    logic [SUM_W-1:0]   mod_step_val;
    logic [7:0]         key_sel;
    logic [127:0]       key_all;

    assign sum = op_a + op_b + op_c;
    assign n10 = SUM_W'(n_eff);
    assign n2  = {n_eff, 1'b0};
    assign n3  = {1'b0, n2} + (SUM_W+1)'(n_eff);

    // Sums below 3N reduce in the same cycle; others go to the iterative path.
    always_comb begin
        fast_ok  = 1'b1;
        fast_val = sum;
        if (sum < n10) begin
            fast_val = sum;
        end else if (sum < n2) begin
            fast_val = sum - n10;
        end else if ({1'b0, sum} < n3) begin
            fast_val = sum - n2;
        end else begin
            fast_ok  = 1'b0;
        end
    end

    // One restoring shift-and-subtract step per cycle.
    assign mod_ext = 18'(mod_val_reg);
    assign mod_cmp = 18'(n_eff) << sh_reg;
    assign mod_step_val = (mod_ext >= mod_cmp) ? SUM_W'(mod_ext - mod_cmp) : mod_val_reg;

    assign key_all = {key_high_reg, key_low_reg};
    assign key_sel = key_all[kidx_reg*8 +: 8];

    // ---------------- sequencer ----------------
    logic              red_go;
    dst_t              red_dst;
    state_t            red_ret;
    logic              fin_valid;
    dst_t              fin_dst;
    logic [ADDR_W-1:0] fin_value;
    logic              last_entry;

    assign last_entry = (k_reg == n_eff - SIZE_W'(1));
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        dst_next     = dst_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        k_next       = k_reg;
        kidx_next    = kidx_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        data_next    = data_reg;
        mod_val_next = mod_val_reg;
        sh_next      = sh_reg;
        ks_out_next  = ks_out_reg;
        cb_out_next  = cb_out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_wa       = '0;
        ram_wd       = '0;
        ram_re       = 1'b0;
        ram_ra       = '0;
        op_a         = '0;
        op_b         = '0;
        op_c         = '0;
        red_go       = 1'b0;
        red_dst      = DST_I;
        red_ret      = ST_IDLE;
        fin_valid    = 1'b0;
        fin_dst      = DST_I;
        fin_value    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next = s_data_byte;
                    if (kind_t'(s_kind) == KIND_REKEY) begin
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = ST_FILL;
                    end else begin
                        // advance i
                        op_a    = SUM_W'(i_reg);
                        op_b    = SUM_W'(1);
                        red_go  = 1'b1;
                        red_dst = DST_I;
                        red_ret = ST_D_RDI;
                    end
                end
            end
            ST_FILL: begin
                ram_we = 1'b1;
                ram_wa = k_reg[ADDR_W-1:0];
                ram_wd = k_reg[7:0];
                if (last_entry) begin
                    k_next     = '0;
                    kidx_next  = '0;
                    j_next     = '0;
                    state_next = ST_SCH_RDK;
                end else begin
                    k_next = k_reg + SIZE_W'(1);
                end
            end
            ST_SCH_RDK: begin
                ram_re     = 1'b1;
                ram_ra     = k_reg[ADDR_W-1:0];
                state_next = ST_SCH_J;
            end
            ST_SCH_J: begin
                si_next = ram_rd;
                op_a    = SUM_W'(j_reg);
                op_b    = SUM_W'(ram_rd);
                op_c    = SUM_W'(key_sel);
                red_go  = 1'b1;
                red_dst = DST_J;
                red_ret = ST_SCH_RDJ;
            end
            ST_SCH_RDJ: begin
                ram_re     = 1'b1;
                ram_ra     = j_reg;
                state_next = ST_SCH_SW1;
            end
            ST_SCH_SW1: begin
                ram_we     = 1'b1;
                ram_wa     = k_reg[ADDR_W-1:0];
                ram_wd     = ram_rd;
                state_next = ST_SCH_SW2;
            end
            ST_SCH_SW2: begin
                ram_we = 1'b1;
                ram_wa = j_reg;
                ram_wd = si_reg;
                if (last_entry) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + SIZE_W'(1);
                    kidx_next  = ({1'b0, kidx_reg} == klen_eff - KLEN_W'(1)) ? '0
                                 : kidx_reg + KIDX_W'(1);
                    state_next = ST_SCH_RDK;
                end
            end
            ST_D_RDI: begin
                ram_re     = 1'b1;
                ram_ra     = i_reg;
                state_next = ST_D_J;
            end
            ST_D_J: begin
                si_next = ram_rd;
                op_a    = SUM_W'(j_reg);
                op_b    = SUM_W'(ram_rd);
                red_go  = 1'b1;
                red_dst = DST_J;
                red_ret = ST_D_RDJ;
            end
            ST_D_RDJ: begin
                ram_re     = 1'b1;
                ram_ra     = j_reg;
                state_next = ST_D_SW1;
            end
            ST_D_SW1: begin
                sj_next    = ram_rd;
                ram_we     = 1'b1;
                ram_wa     = i_reg;
                ram_wd     = ram_rd;
                state_next = ST_D_SW2;
            end
            ST_D_SW2: begin
                ram_we  = 1'b1;
                ram_wa  = j_reg;
                ram_wd  = si_reg;
                op_a    = SUM_W'(si_reg);
                op_b    = SUM_W'(sj_reg);
                red_go  = 1'b1;
                red_dst = DST_T;
                red_ret = ST_D_RDT;
            end
            ST_D_RDT: begin
                ram_re     = 1'b1;
                ram_ra     = t_reg;
                state_next = ST_D_OUT;
            end
            ST_D_OUT: begin
                // hold here while a previous result still waits
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    ks_out_next  = ram_rd;
                    cb_out_next  = data_reg ^ ram_rd;
                    state_next   = ST_IDLE;
                end
            end
            ST_MOD: begin
                mod_val_next = mod_step_val;
                if (sh_reg == '0) begin
                    fin_valid  = 1'b1;
                    fin_dst    = dst_reg;
                    fin_value  = mod_step_val[ADDR_W-1:0];
                    state_next = ret_reg;
                end else begin
                    sh_next = sh_reg - SHIFT_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a reduction: finish now when the sum is small, else iterate.
        if (red_go) begin
            if (fast_ok) begin
                fin_valid  = 1'b1;
                fin_dst    = red_dst;
                fin_value  = fast_val[ADDR_W-1:0];
                state_next = red_ret;
            end else begin
                mod_val_next = sum;
                sh_next      = SHIFT_W'(MOD_TOP_SHIFT);
                dst_next     = red_dst;
                ret_next     = red_ret;
                state_next   = ST_MOD;
            end
        end

        if (fin_valid) begin
            case (fin_dst)
                DST_I:   i_next = fin_value;
                DST_J:   j_next = fin_value;
                DST_T:   t_next = fin_value;
                default: ;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_keystream_value = ks_out_reg;
    assign m_cipher_byte     = cb_out_reg;

    // ---------------- assertions ----------------
    // A result appears only out of the output state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_D_OUT))
        else $error("result raised outside the output state");

    // Reduced indices stay below N when they address the RAM.
    a_i_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_D_RDI) |-> (SIZE_W'(i_reg) < n_eff))
        else $error("index i not reduced below N");

    a_j_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_D_RDJ || state_reg == ST_SCH_RDJ) |-> (SIZE_W'(j_reg) < n_eff))
        else $error("index j not reduced below N");

    a_t_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_D_RDT) |-> (SIZE_W'(t_reg) < n_eff))
        else $error("index t not reduced below N");

    // The fill and the schedule walk only entries below N.
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCH_RDK || state_reg == ST_FILL) |-> (k_reg < n_eff))
        else $error("schedule counter past N");

endmodule

[rtl/rc4ks_ram.sv]
// ----------------------------------------------------------------------------
// rc4ks_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rc4ks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
